[hw/rtl/operand_address_mode_decode_core_assert.svh]
// Assertion macros shared by the checker of the operand decode core.
`ifndef OPERAND_ADDRESS_MODE_DECODE_CORE_ASSERT_SVH
`define OPERAND_ADDRESS_MODE_DECODE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OAMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OAMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/oamd_pkg.sv]
package oamd_pkg;

    // Base addresses of the high pages used by 16- and 8-bit addressing.
    localparam logic [31:0] HIGH_PAGE16 = 32'hFFFF_0000;
    localparam logic [31:0] HIGH_PAGE8  = 32'hFFFF_FF00;

    // Register size codes, taken from the low two bits of a register code.
    localparam logic [1:0] SIZE_32 = 2'b00;
    localparam logic [1:0] SIZE_16 = 2'b01;

    // Byte counts used for read sizes and program counter advance.
    localparam logic [2:0] BYTES_0 = 3'd0;
    localparam logic [2:0] BYTES_1 = 3'd1;
    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_4 = 3'd4;

    // Addressing modes, in instruction function order.
    typedef enum logic [4:0] {
        MODE_REG_IMM       = 5'd0,
        MODE_REG_ADDR32    = 5'd1,
        MODE_REG_REGPTR32  = 5'd2,
        MODE_REG_ADDR16    = 5'd3,
        MODE_REG_REGPTR16  = 5'd4,
        MODE_REG8_ADDR8    = 5'd5,
        MODE_REG8_REGPTR8  = 5'd6,
        MODE_ADDR32_REG    = 5'd7,
        MODE_REGPTR32_REG  = 5'd8,
        MODE_ADDR16_REG    = 5'd9,
        MODE_REGPTR16_REG  = 5'd10,
        MODE_ADDR8_REG8    = 5'd11,
        MODE_REGPTR8_REG8  = 5'd12,
        MODE_REG_REG       = 5'd13,
        MODE_NULL_IMM32    = 5'd14,
        MODE_NULL_REG32    = 5'd15,
        MODE_NULL_SIMM16   = 5'd16,
        MODE_REG_NULL      = 5'd17,
        MODE_REGPTR32_NULL = 5'd18,
        MODE_IMM8_REG      = 5'd19,
        MODE_IMM8_REGPTR32 = 5'd20
    } t_mode;

    // One input word.
    typedef struct packed {
        logic [4:0]  func;
        logic [7:0]  reg_codes;
        logic [31:0] immediate;
        logic [31:0] src_value;
        logic [31:0] dst_value;
    } t_item;

    // One result word.
    typedef struct packed {
        logic        fault;
        logic [31:0] read_addr;
        logic [2:0]  read_bytes;
        logic [31:0] src_data;
        logic [31:0] dst_addr;
        logic        dst_valid;
        logic        check_write;
        logic [2:0]  pc_advance;
    } t_result;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

endpackage

[hw/rtl/oamd_stage.sv]
module oamd_stage
    import oamd_pkg::*;
#(
    parameter int W = ITEM_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    // The stage takes a new word when empty or when its word leaves this cycle.
    assign o_ready = !r_valid || i_ready;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register, loaded only on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/oamd_decode.sv]
module oamd_decode
    import oamd_pkg::*;
(
    input  t_item   i_item,
    output t_result o_result
);

    logic [1:0]  dsz;
    logic [1:0]  ssz;
    logic [2:0]  dbytes;
    logic [31:0] imm16;
    logic [31:0] imm8;
    logic [31:0] imm_dst;
    t_result     res;

    assign dsz   = i_item.reg_codes[5:4];
    assign ssz   = i_item.reg_codes[1:0];
    assign imm16 = {16'h0000, i_item.immediate[15:0]};
    assign imm8  = {24'h00_0000, i_item.immediate[7:0]};

    // Destination register size gives the byte count and the sized immediate.
    always_comb begin
        unique case (dsz)
            SIZE_32: begin
                dbytes  = BYTES_4;
                imm_dst = i_item.immediate;
            end
            SIZE_16: begin
                dbytes  = BYTES_2;
                imm_dst = imm16;
            end
            default: begin
                dbytes  = BYTES_1;
                imm_dst = imm8;
            end
        endcase
    end

    // Per-mode operand decode; a size violation or unknown mode zeroes everything but the fault.
    always_comb begin
        res = '0;
        unique case (t_mode'(i_item.func))
            MODE_REG_IMM: begin
                res.pc_advance = dbytes;
                res.src_data   = imm_dst;
            end
            MODE_REG_ADDR32: begin
                res.read_addr  = i_item.immediate;
                res.pc_advance = BYTES_4;
                res.read_bytes = dbytes;
            end
            MODE_REG_REGPTR32: begin
                res.fault      = (ssz != SIZE_32);
                res.read_addr  = i_item.src_value;
                res.read_bytes = dbytes;
            end
            MODE_REG_ADDR16: begin
                res.read_addr  = {HIGH_PAGE16[31:16], i_item.immediate[15:0]};
                res.pc_advance = BYTES_2;
                res.read_bytes = dbytes;
            end
            MODE_REG_REGPTR16: begin
                res.fault      = (ssz != SIZE_16);
                res.read_addr  = HIGH_PAGE16 + i_item.src_value;
                res.read_bytes = dbytes;
            end
            MODE_REG8_ADDR8: begin
                res.fault      = !dsz[1];
                res.read_addr  = {HIGH_PAGE8[31:8], i_item.immediate[7:0]};
                res.pc_advance = BYTES_1;
                res.read_bytes = BYTES_1;
            end
            MODE_REG8_REGPTR8: begin
                res.fault      = !dsz[1] || !ssz[1];
                res.read_addr  = HIGH_PAGE8 + i_item.src_value;
                res.read_bytes = BYTES_1;
            end
            MODE_ADDR32_REG: begin
                res.dst_addr    = i_item.immediate;
                res.dst_valid   = 1'b1;
                res.check_write = 1'b1;
                res.pc_advance  = BYTES_4;
                res.src_data    = i_item.src_value;
            end
            MODE_REGPTR32_REG: begin
                res.fault       = (dsz != SIZE_32);
                res.dst_addr    = i_item.dst_value;
                res.dst_valid   = 1'b1;
                res.check_write = 1'b1;
                res.src_data    = i_item.src_value;
            end
            MODE_ADDR16_REG: begin
                res.dst_addr   = {HIGH_PAGE16[31:16], i_item.immediate[15:0]};
                res.dst_valid  = 1'b1;
                res.pc_advance = BYTES_2;
                res.src_data   = i_item.src_value;
            end
            MODE_REGPTR16_REG: begin
                res.fault     = (dsz != SIZE_16);
                res.dst_addr  = HIGH_PAGE16 + i_item.dst_value;
                res.dst_valid = 1'b1;
                res.src_data  = i_item.src_value;
            end
            MODE_ADDR8_REG8: begin
                res.fault      = !ssz[1];
                res.dst_addr   = {HIGH_PAGE8[31:8], i_item.immediate[7:0]};
                res.dst_valid  = 1'b1;
                res.pc_advance = BYTES_1;
                res.src_data   = i_item.src_value;
            end
            MODE_REGPTR8_REG8: begin
                res.fault     = !dsz[1] || !ssz[1];
                res.dst_addr  = HIGH_PAGE8 + i_item.dst_value;
                res.dst_valid = 1'b1;
                res.src_data  = i_item.src_value;
            end
            MODE_REG_REG: begin
                res.src_data = i_item.src_value;
            end
            MODE_NULL_IMM32: begin
                res.src_data   = i_item.immediate;
                res.pc_advance = BYTES_4;
            end
            MODE_NULL_REG32: begin
                res.fault    = (ssz != SIZE_32);
                res.src_data = i_item.src_value;
            end
            MODE_NULL_SIMM16: begin
                res.src_data   = imm16;
                res.pc_advance = BYTES_2;
            end
            MODE_REG_NULL: begin
                res.src_data = i_item.dst_value;
            end
            MODE_REGPTR32_NULL: begin
                res.fault       = (ssz != SIZE_32);
                res.dst_addr    = i_item.src_value;
                res.dst_valid   = 1'b1;
                res.check_write = 1'b1;
                res.read_addr   = i_item.src_value;
                res.read_bytes  = BYTES_1;
            end
            MODE_IMM8_REG: begin
                res.src_data = i_item.dst_value;
            end
            MODE_IMM8_REGPTR32: begin
                res.fault       = (dsz != SIZE_32);
                res.dst_addr    = i_item.dst_value;
                res.dst_valid   = 1'b1;
                res.check_write = 1'b1;
                res.read_addr   = i_item.dst_value;
                res.read_bytes  = BYTES_1;
            end
            default: begin
                res.fault = 1'b1;
            end
        endcase

        if (res.fault) begin
            res       = '0;
            res.fault = 1'b1;
        end
    end

    assign o_result = res;

endmodule

[hw/rtl/operand_address_mode_decode_core.sv]
// Operand address-mode decode core.
// A word accepted into the input register goes through the decode logic into the result
// register. Throughput: one word per cycle while i_out_ready does not stall the output;
// the result register frees in the cycle its word leaves.
// Reset (synchronous, active low) empties both registers; no result is pending after it.
module operand_address_mode_decode_core
    import oamd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_func,
    input  logic [7:0]  i_reg_codes,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_src_value,
    input  logic [31:0] i_dst_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fault,
    output logic [31:0] o_read_addr,
    output logic [2:0]  o_read_bytes,
    output logic [31:0] o_src_data,
    output logic [31:0] o_dst_addr,
    output logic        o_dst_valid,
    output logic        o_check_write,
    output logic [2:0]  o_pc_advance
);

    t_item   in_item;
    t_item   held_item;
    t_result dec_result;
    t_result out_result;
    logic    dec_valid;
    logic    res_ready;

    assign in_item = '{
        func:      i_func,
        reg_codes: i_reg_codes,
        immediate: i_immediate,
        src_value: i_src_value,
        dst_value: i_dst_value
    };

    // Input register.
    oamd_stage #(
        .W (ITEM_W)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (in_item),
        .o_valid (dec_valid),
        .i_ready (res_ready),
        .o_data  (held_item)
    );

    // Operand decode between the two registers.
    oamd_decode u_decode (
        .i_item   (held_item),
        .o_result (dec_result)
    );

    // Result register.
    oamd_stage #(
        .W (RESULT_W)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (res_ready),
        .i_data  (dec_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_fault       = out_result.fault;
    assign o_read_addr   = out_result.read_addr;
    assign o_read_bytes  = out_result.read_bytes;
    assign o_src_data    = out_result.src_data;
    assign o_dst_addr    = out_result.dst_addr;
    assign o_dst_valid   = out_result.dst_valid;
    assign o_check_write = out_result.check_write;
    assign o_pc_advance  = out_result.pc_advance;

endmodule

[hw/rtl/oamd_checker.sv]
`include "operand_address_mode_decode_core_assert.svh"

module oamd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_fault,
    input logic [31:0] o_read_addr,
    input logic [2:0]  o_read_bytes,
    input logic [31:0] o_src_data,
    input logic [31:0] o_dst_addr,
    input logic        o_dst_valid,
    input logic        o_check_write,
    input logic [2:0]  o_pc_advance
);

    logic         rest_zero;
    logic         read_legal;
    logic [104:0] out_word;

    // Every field but the fault is zero.
    assign rest_zero = (o_read_addr == 32'd0) && (o_read_bytes == 3'd0)
        && (o_src_data == 32'd0) && (o_dst_addr == 32'd0) && !o_dst_valid
        && !o_check_write && (o_pc_advance == 3'd0);

    // A read has no direct source value and one of the legal sizes.
    assign read_legal = (o_src_data == 32'd0)
        && ((o_read_bytes == 3'd1) || (o_read_bytes == 3'd2) || (o_read_bytes == 3'd4));

    // The whole result word, for the hold check.
    assign out_word = {o_fault, o_read_addr, o_read_bytes, o_src_data, o_dst_addr,
                       o_dst_valid, o_check_write, o_pc_advance};

    // A faulting word carries nothing else.
    `OAMD_ASSERT_NOW(a_fault_clears, o_out_valid && o_fault, rest_zero, "fault word not clear")

    // A write check is only requested for a real destination address.
    `OAMD_ASSERT_NOW(a_check_needs_dst, o_out_valid && o_check_write, o_dst_valid, "check no dst")

    // A memory read excludes a direct source value and has a legal size.
    `OAMD_ASSERT_NOW(a_read_excl, o_out_valid && (o_read_bytes != 3'd0), read_legal, "bad read")

    // A stalled result word holds.
    `OAMD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word), "stalled result changed")

endmodule

bind operand_address_mode_decode_core oamd_checker u_oamd_checker (.*);

[tb/testbench.sv]
import oamd_pkg::*;

// Scoreboard for the operand decode core: predicts the result of every accepted
// input word and compares it with the words that leave the block, in order.
class operand_decode_board;

    t_result pending[$];
    int      mismatches;

    function new();
        mismatches = 0;
    endfunction

    // True when a size code names an 8-bit register.
    function automatic bit is_byte_reg(logic [1:0] sz);
        return sz[1];
    endfunction

    // Works out the decode of one input word.
    function automatic t_result decode_operands(t_item w);
        t_result    r;
        logic [1:0] dsz;
        logic [1:0] ssz;
        logic [2:0] dbytes;
        logic       bad;
        r      = '0;
        bad    = 1'b0;
        dsz    = w.reg_codes[5:4];
        ssz    = w.reg_codes[1:0];
        dbytes = (dsz == SIZE_32) ? BYTES_4 : ((dsz == SIZE_16) ? BYTES_2 : BYTES_1);
        case (w.func)
            MODE_REG_IMM: begin
                r.pc_advance = dbytes;
                if (dbytes == BYTES_4) r.src_data = w.immediate;
                else if (dbytes == BYTES_2) r.src_data = {16'h0, w.immediate[15:0]};
                else r.src_data = {24'h0, w.immediate[7:0]};
            end
            MODE_REG_ADDR32: begin
                r.read_addr  = w.immediate;
                r.read_bytes = dbytes;
                r.pc_advance = BYTES_4;
            end
            MODE_REG_REGPTR32: begin
                bad          = (ssz != SIZE_32);
                r.read_addr  = w.src_value;
                r.read_bytes = dbytes;
            end
            MODE_REG_ADDR16: begin
                r.read_addr  = HIGH_PAGE16 + {16'h0, w.immediate[15:0]};
                r.read_bytes = dbytes;
                r.pc_advance = BYTES_2;
            end
            MODE_REG_REGPTR16: begin
                bad          = (ssz != SIZE_16);
                r.read_addr  = HIGH_PAGE16 + w.src_value;
                r.read_bytes = dbytes;
            end
            MODE_REG8_ADDR8: begin
                bad          = !is_byte_reg(dsz);
                r.read_addr  = HIGH_PAGE8 + {24'h0, w.immediate[7:0]};
                r.read_bytes = BYTES_1;
                r.pc_advance = BYTES_1;
            end
            MODE_REG8_REGPTR8: begin
                bad          = !is_byte_reg(dsz) || !is_byte_reg(ssz);
                r.read_addr  = HIGH_PAGE8 + w.src_value;
                r.read_bytes = BYTES_1;
            end
            MODE_ADDR32_REG: begin
                r.dst_addr    = w.immediate;
                r.dst_valid   = 1'b1;
                r.check_write = 1'b1;
                r.pc_advance  = BYTES_4;
                r.src_data    = w.src_value;
            end
            MODE_REGPTR32_REG: begin
                bad           = (dsz != SIZE_32);
                r.dst_addr    = w.dst_value;
                r.dst_valid   = 1'b1;
                r.check_write = 1'b1;
                r.src_data    = w.src_value;
            end
            MODE_ADDR16_REG: begin
                r.dst_addr   = HIGH_PAGE16 + {16'h0, w.immediate[15:0]};
                r.dst_valid  = 1'b1;
                r.pc_advance = BYTES_2;
                r.src_data   = w.src_value;
            end
            MODE_REGPTR16_REG: begin
                bad         = (dsz != SIZE_16);
                r.dst_addr  = HIGH_PAGE16 + w.dst_value;
                r.dst_valid = 1'b1;
                r.src_data  = w.src_value;
            end
            MODE_ADDR8_REG8: begin
                bad          = !is_byte_reg(ssz);
                r.dst_addr   = HIGH_PAGE8 + {24'h0, w.immediate[7:0]};
                r.dst_valid  = 1'b1;
                r.pc_advance = BYTES_1;
                r.src_data   = w.src_value;
            end
            MODE_REGPTR8_REG8: begin
                bad         = !is_byte_reg(dsz) || !is_byte_reg(ssz);
                r.dst_addr  = HIGH_PAGE8 + w.dst_value;
                r.dst_valid = 1'b1;
                r.src_data  = w.src_value;
            end
            MODE_REG_REG: begin
                r.src_data = w.src_value;
            end
            MODE_NULL_IMM32: begin
                r.src_data   = w.immediate;
                r.pc_advance = BYTES_4;
            end
            MODE_NULL_REG32: begin
                bad        = (ssz != SIZE_32);
                r.src_data = w.src_value;
            end
            MODE_NULL_SIMM16: begin
                // The 16-bit immediate is zero-extended despite the mode's name.
                r.src_data   = {16'h0, w.immediate[15:0]};
                r.pc_advance = BYTES_2;
            end
            MODE_REG_NULL: begin
                r.src_data = w.dst_value;
            end
            MODE_REGPTR32_NULL: begin
                bad           = (ssz != SIZE_32);
                r.dst_addr    = w.src_value;
                r.dst_valid   = 1'b1;
                r.check_write = 1'b1;
                r.read_addr   = w.src_value;
                r.read_bytes  = BYTES_1;
            end
            MODE_IMM8_REG: begin
                r.src_data = w.dst_value;
            end
            MODE_IMM8_REGPTR32: begin
                bad           = (dsz != SIZE_32);
                r.dst_addr    = w.dst_value;
                r.dst_valid   = 1'b1;
                r.check_write = 1'b1;
                r.read_addr   = w.dst_value;
                r.read_bytes  = BYTES_1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        // A fault clears every other field.
        if (bad) r = '0;
        r.fault = bad;
        return r;
    endfunction

    function automatic string show(t_result r);
        return $sformatf("flt=%0d ra=%h rb=%0d sd=%h da=%h dv=%0d cw=%0d pc=%0d",
            r.fault, r.read_addr, r.read_bytes, r.src_data, r.dst_addr,
            r.dst_valid, r.check_write, r.pc_advance);
    endfunction

    // Records the expected result of an accepted input word.
    function void note_word(t_item w);
        pending.push_back(decode_operands(w));
    endfunction

    // Compares one result word with the oldest expectation.
    function void check_word(t_result got);
        t_result exp;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %s", show(got));
            return;
        end
        exp = pending.pop_front();
        if (got.fault !== exp.fault || got.read_addr !== exp.read_addr ||
            got.read_bytes !== exp.read_bytes || got.src_data !== exp.src_data ||
            got.dst_addr !== exp.dst_addr || got.dst_valid !== exp.dst_valid ||
            got.check_write !== exp.check_write || got.pc_advance !== exp.pc_advance) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch expected: %s", show(exp));
                $display("         actual:   %s", show(got));
            end
        end
    endfunction

endclass

module testbench;

    localparam int RANDOM_WORDS = 1600;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [4:0]  i_func = '0;
    logic [7:0]  i_reg_codes = '0;
    logic [31:0] i_immediate = '0;
    logic [31:0] i_src_value = '0;
    logic [31:0] i_dst_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_fault;
    logic [31:0] o_read_addr;
    logic [2:0]  o_read_bytes;
    logic [31:0] o_src_data;
    logic [31:0] o_dst_addr;
    logic        o_dst_valid;
    logic        o_check_write;
    logic [2:0]  o_pc_advance;

    int          cycle_count = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;

    operand_decode_board board = new();

    operand_address_mode_decode_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_reg_codes   (i_reg_codes),
        .i_immediate   (i_immediate),
        .i_src_value   (i_src_value),
        .i_dst_value   (i_dst_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fault       (o_fault),
        .o_read_addr   (o_read_addr),
        .o_read_bytes  (o_read_bytes),
        .o_src_data    (o_src_data),
        .o_dst_addr    (o_dst_addr),
        .o_dst_valid   (o_dst_valid),
        .o_check_write (o_check_write),
        .o_pc_advance  (o_pc_advance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result side: check each accepted word, then stall on a rotating pattern
    // that is reloaded now and then. Bit 0 is forced on in every pattern so that
    // each rotation of the pattern gives the result side a ready cycle.
    always @(posedge i_clk) begin : result_side
        logic [15:0] fresh;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_word('{o_fault, o_read_addr, o_read_bytes, o_src_data,
                               o_dst_addr, o_dst_valid, o_check_write, o_pc_advance});
        end
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: fresh = 16'hFFFF;
                1: fresh = 16'($urandom);
                2: fresh = 16'($urandom & $urandom);
                default: fresh = 16'($urandom | $urandom);
            endcase
            fresh = fresh | 16'h0001;
            stall_pattern <= fresh;
            pattern_age   <= $urandom_range(40, 300);
            i_out_ready   <= fresh[0];
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_age   <= pattern_age - 1;
            i_out_ready   <= stall_pattern[1];
        end
    end

    // Offers one word and returns at the edge where it is accepted.
    task automatic send_word(input t_item w);
        i_in_valid  <= 1'b1;
        i_func      <= w.func;
        i_reg_codes <= w.reg_codes;
        i_immediate <= w.immediate;
        i_src_value <= w.src_value;
        i_dst_value <= w.dst_value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_word(w);
    endtask

    task automatic sender_gap(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Register codes for a mode; with legal set, the size bits obey the mode's rules.
    function automatic logic [7:0] codes_for(logic [4:0] mode, bit legal);
        logic [7:0] c;
        c = 8'($urandom);
        if (legal) begin
            case (mode)
                MODE_REG_REGPTR32, MODE_NULL_REG32, MODE_REGPTR32_NULL: c[1:0] = SIZE_32;
                MODE_REG_REGPTR16: c[1:0] = SIZE_16;
                MODE_REG8_ADDR8: c[5] = 1'b1;
                MODE_REG8_REGPTR8, MODE_REGPTR8_REG8: begin
                    c[5] = 1'b1;
                    c[1] = 1'b1;
                end
                MODE_REGPTR32_REG, MODE_IMM8_REGPTR32: c[5:4] = SIZE_32;
                MODE_REGPTR16_REG: c[5:4] = SIZE_16;
                MODE_ADDR8_REG8: c[1] = 1'b1;
                default: ;
            endcase
        end
        return c;
    endfunction

    // Operand values biased toward page and wrap boundaries.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_FFFF;
            3: return 32'h0000_00FF;
            4: return 32'h0001_0000;
            5: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item random_word();
        t_item w;
        if ($urandom_range(0, 9) == 0) w.func = 5'($urandom_range(0, 31));
        else w.func = 5'($urandom_range(0, 20));
        w.reg_codes = codes_for(w.func, $urandom_range(0, 4) != 0);
        w.immediate = pick_value();
        w.src_value = pick_value();
        w.dst_value = pick_value();
        return w;
    endfunction

    // Every mode once with legal sizes and all-ones operands, then size
    // violations, unknown modes and an all-zero word.
    task automatic run_directed();
        t_item w;
        for (int m = 0; m <= 20; m++) begin
            w.func      = m[4:0];
            w.reg_codes = codes_for(w.func, 1'b1);
            w.immediate = 32'hFFFF_FFFF;
            w.src_value = 32'hFFFF_FFFF;
            w.dst_value = 32'hFFFF_FFFF;
            send_word(w);
        end
        send_word('{MODE_REG_REGPTR32, 8'h01, 32'h1234_5678, 32'h0, 32'h0});
        send_word('{MODE_REG8_ADDR8, 8'h00, 32'hFF, 32'h0, 32'h0});
        send_word('{5'd21, 8'hEE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word('{5'd31, 8'h00, 32'h1, 32'h1, 32'h1});
        send_word('{MODE_REG_IMM, 8'h00, 32'h0, 32'h0, 32'h0});
    endtask

    // Random words in bursts; with bursty clear the words go back to back.
    task automatic run_random(input int count, input bit bursty);
        int burst_left;
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < count; n++) begin
            send_word(random_word());
            burst_left--;
            if (bursty && burst_left == 0 && n != count - 1) begin
                sender_gap($urandom_range(1, 8));
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        sender_gap($urandom_range(1, 4));
        run_random(RANDOM_WORDS / 4, 1'b0);
        run_random(RANDOM_WORDS / 2, 1'b1);
        run_random(RANDOM_WORDS / 8, 1'b0);
        run_random(RANDOM_WORDS / 8, 1'b1);
        i_in_valid <= 1'b0;
        // Drain the pipeline, then keep watching for stray words.
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
